[rtl/core/asf_data_packet_header_parser_top_macros.svh]
// Assertion macros for the ASF data-packet header parser checker.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef ASF_DATA_PACKET_HEADER_PARSER_TOP_MACROS_SVH
`define ASF_DATA_PACKET_HEADER_PARSER_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define ASFDP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("asfdp check failed");

// Check cons in the cycle after ante.
`define ASFDP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("asfdp check failed");

`endif

[rtl/core/asfdp_pkg.sv]
// Shared types and constants of the ASF data-packet header parser.
// No dependencies; imported by the parse core and the top level.
package asfdp_pkg;

    typedef enum logic [4:0] {
        PH_FIRST   = 5'd0,
        PH_ECSKIP  = 5'd1,
        PH_LENTYPE = 5'd2,
        PH_PROP    = 5'd3,
        PH_PSIZE   = 5'd4,
        PH_SEQ     = 5'd5,
        PH_PAD     = 5'd6,
        PH_TIME    = 5'd7,
        PH_PFLAGS  = 5'd8,
        PH_STREAM  = 5'd9,
        PH_MOBJ    = 5'd10,
        PH_OFFSET  = 5'd11,
        PH_REPLEN  = 5'd12,
        PH_REPSKIP = 5'd13,
        PH_PLEN    = 5'd14,
        PH_PAYSKIP = 5'd15,
        PH_PADSKIP = 5'd16
    } phase_t;

    localparam int unsigned SETTLE_STEPS = 7;
    localparam logic [31:0] TIME_FIELD_LEN = 32'd6;
    localparam logic [31:0] PLEN_FIELD_LEN = 32'd2;
    localparam logic [31:0] BYTE_FIELD_LEN = 32'd1;
    localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  ltf;
        logic [7:0]  pf;
        logic [31:0] bl;
        logic [31:0] acc;
        logic [1:0]  idx;
        logic [31:0] ps;
        logic [31:0] pad;
        logic [31:0] hdr;
        logic [6:0]  stream;
        logic [31:0] obj;
        logic [5:0]  pl;
        logic        mm;
    } parse_state_t;

    typedef struct packed {
        logic [6:0]  stream;
        logic [31:0] obj;
        logic [31:0] size;
        logic        last;
        logic        under;
    } payload_rec_t;

    typedef struct packed {
        parse_state_t st;
        logic         rec_valid;
        payload_rec_t rec;
    } step_t;

endpackage

[rtl/core/asfdp_parse_core.sv]
// Parse state and combinational byte step of the ASF data-packet header parser.
// Depends on asfdp_pkg.
module asfdp_parse_core
    import asfdp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  logic [7:0]   data_byte,
    input  logic [31:0]  min_packet_size,
    output logic         rec_valid,
    output payload_rec_t rec
);

    parse_state_t       state_reg;
    parse_state_t       state_next;
    logic signed [32:0] room_reg;
    logic signed [32:0] room_next;
    logic [31:0]        total;
    logic [31:0]        hdr_step;
    logic [33:0]        size_diff;
    logic [31:0]        single_size;
    logic               single_under;
    logic               is_first;
    step_t              step_res;

    function automatic logic [31:0] code_len(input logic [1:0] c);
        logic [31:0] r;
        r = (c == 2'd3) ? 32'd4 : {30'd0, c};
        return r;
    endfunction

    function automatic logic [31:0] phase_len(input parse_state_t s);
        logic [31:0] r;
        case (s.phase)
            PH_PSIZE:   r = code_len(s.ltf[6:5]);
            PH_SEQ:     r = code_len(s.ltf[2:1]);
            PH_PAD:     r = code_len(s.ltf[4:3]);
            PH_TIME:    r = TIME_FIELD_LEN;
            PH_MOBJ:    r = code_len(s.pf[5:4]);
            PH_OFFSET:  r = code_len(s.pf[3:2]);
            PH_REPLEN:  r = code_len(s.pf[1:0]);
            PH_PLEN:    r = PLEN_FIELD_LEN;
            PH_ECSKIP:  r = s.bl;
            PH_REPSKIP: r = s.bl;
            PH_PAYSKIP: r = s.bl;
            PH_PADSKIP: r = s.bl;
            default:    r = BYTE_FIELD_LEN;
        endcase
        return r;
    endfunction

    function automatic step_t complete_fn(input step_t x, input logic [31:0] v,
                                          input logic [31:0] sz, input logic un);
        step_t y;
        y = x;
        case (x.st.phase)
            PH_ECSKIP:  y.st.phase = PH_LENTYPE;
            PH_LENTYPE:
            begin
                y.st.ltf   = v[7:0];
                y.st.phase = PH_PROP;
            end
            PH_PROP:
            begin
                y.st.pf    = v[7:0];
                y.st.mm    = x.st.ltf[0];
                y.st.phase = PH_PSIZE;
            end
            PH_PSIZE:
            begin
                y.st.ps    = v;
                y.st.phase = PH_SEQ;
            end
            PH_SEQ:     y.st.phase = PH_PAD;
            PH_PAD:
            begin
                y.st.pad   = v;
                y.st.phase = PH_TIME;
            end
            PH_TIME:    y.st.phase = x.st.mm ? PH_PFLAGS : PH_STREAM;
            PH_PFLAGS:
            begin
                y.st.pl = v[5:0];
                if (v[5:0] != 6'd0)
                begin
                    y.st.phase = PH_STREAM;
                end
                else
                begin
                    y.st.bl    = x.st.pad;
                    y.st.phase = PH_PADSKIP;
                end
            end
            PH_STREAM:
            begin
                y.st.stream = v[6:0];
                y.st.phase  = PH_MOBJ;
            end
            PH_MOBJ:
            begin
                y.st.obj   = v;
                y.st.phase = PH_OFFSET;
            end
            PH_OFFSET:  y.st.phase = PH_REPLEN;
            PH_REPLEN:
            begin
                y.st.bl    = v;
                y.st.phase = PH_REPSKIP;
            end
            PH_REPSKIP:
            begin
                if (x.st.mm)
                begin
                    y.st.phase = PH_PLEN;
                end
                else
                begin
                    y.rec_valid  = 1'b1;
                    y.rec.stream = x.st.stream;
                    y.rec.obj    = x.st.obj;
                    y.rec.size   = sz;
                    y.rec.last   = 1'b1;
                    y.rec.under  = un;
                    y.st.bl      = sz;
                    y.st.phase   = PH_PAYSKIP;
                end
            end
            PH_PLEN:
            begin
                y.rec_valid  = 1'b1;
                y.rec.stream = x.st.stream;
                y.rec.obj    = x.st.obj;
                y.rec.size   = {16'd0, v[15:0]};
                y.rec.last   = (x.st.pl == 6'd1);
                y.rec.under  = 1'b0;
                y.st.pl      = x.st.pl - 6'd1;
                y.st.bl      = {16'd0, v[15:0]};
                y.st.phase   = PH_PAYSKIP;
            end
            PH_PAYSKIP:
            begin
                if (x.st.mm && (x.st.pl != 6'd0))
                begin
                    y.st.phase = PH_STREAM;
                end
                else
                begin
                    y.st.bl    = x.st.pad;
                    y.st.phase = PH_PADSKIP;
                end
            end
            default:    y.st.phase = PH_FIRST;
        endcase
        return y;
    endfunction

    assign is_first = (state_reg.phase == PH_FIRST) || (state_reg.phase > PH_PADSKIP);

    always_comb
    begin
        if (is_first)
        begin
            hdr_step = 32'd1;
        end
        else if (state_reg.hdr == COUNT_MAX)
        begin
            hdr_step = state_reg.hdr;
        end
        else
        begin
            hdr_step = state_reg.hdr + 32'd1;
        end
    end

    // Hold packet room less padding, ready for the single-payload size.
    assign total     = (state_reg.ps < min_packet_size) ? min_packet_size : state_reg.ps;
    assign room_next = $signed({1'b0, total}) - $signed({1'b0, state_reg.pad});

    assign size_diff    = {room_reg[32], room_reg} - {2'b00, hdr_step};
    assign single_under = size_diff[33];
    assign single_size  = single_under ? 32'd0 : size_diff[31:0];

    always_comb
    begin
        step_t       x;
        logic [31:0] len;
        logic        need;
        x           = '0;
        x.st        = state_reg;
        x.st.hdr    = hdr_step;
        len         = '0;
        need        = 1'b0;
        if (is_first)
        begin
            if (data_byte[7])
            begin
                x.st.bl    = {28'd0, data_byte[3:0]};
                x.st.phase = PH_ECSKIP;
            end
            else
            begin
                x.st.ltf   = data_byte;
                x.st.phase = PH_PROP;
            end
            need = 1'b1;
        end
        else
        begin
            case (state_reg.phase)
                PH_PSIZE, PH_PAD, PH_MOBJ, PH_REPLEN, PH_PLEN:
                begin
                    x.st.acc = state_reg.acc
                             | ({24'd0, data_byte} << {state_reg.idx, 3'b000});
                    x.st.idx = state_reg.idx + 2'd1;
                end
                PH_LENTYPE, PH_PROP, PH_PFLAGS, PH_STREAM:
                begin
                    x.st.acc = {24'd0, data_byte};
                end
                default:
                begin
                    x.st.acc = state_reg.acc;
                end
            endcase
            x.st.bl = state_reg.bl - 32'd1;
            if (x.st.bl == 32'd0)
            begin
                x    = complete_fn(x, x.st.acc, single_size, single_under);
                need = 1'b1;
            end
        end
        // Advance through empty fields until one that takes bytes.
        for (int i = 0; i < SETTLE_STEPS; i++)
        begin
            if (need)
            begin
                len = phase_len(x.st);
                if (len == 32'd0)
                begin
                    x = complete_fn(x, 32'd0, single_size, single_under);
                end
                else
                begin
                    x.st.bl  = len;
                    x.st.acc = 32'd0;
                    x.st.idx = 2'd0;
                    need     = 1'b0;
                end
            end
        end
        step_res = x;
    end

    always_comb
    begin
        state_next = fire ? step_res.st : state_reg;
    end

    always_comb
    begin
        rec_valid = step_res.rec_valid;
        rec       = step_res.rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase: PH_FIRST, default: '0};
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        room_reg <= room_next;
    end

endmodule

[rtl/core/asf_data_packet_header_parser_top.sv]
// Top level of the ASF data-packet header parser: handshakes, config register, result register.
// Depends on asfdp_pkg and asfdp_parse_core.
//
// Takes one stream byte per cycle, sustained while the result side does not stall, with no gaps
// between packets. A byte waits in the input register, then a combinational parse step updates
// the header state and, where the byte finishes a payload header, loads the result register.
// Empty size fields and empty skips resolve inside that step. The result register holds under
// back pressure while one more byte waits in the input register. Write min_packet_size only when
// no byte is in flight.
module asf_data_packet_header_parser_top
    import asfdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  stream_number,
    output logic [31:0] media_object_number,
    output logic [31:0] payload_len,
    output logic        last_of_packet,
    output logic        size_underflow,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   in_data_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    payload_rec_t out_rec_reg;
    logic [31:0]  min_size_reg;
    logic         out_free;
    logic         fire;
    logic         in_accept;
    logic         rec_valid;
    payload_rec_t rec;

    assign out_free  = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    asfdp_parse_core u_parse_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .data_byte       (in_data_reg),
        .min_packet_size (min_size_reg),
        .rec_valid       (rec_valid),
        .rec             (rec)
    );

    always_comb
    begin
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_comb
    begin
        if (out_free)
        begin
            out_valid_next = fire && rec_valid;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            min_size_reg  <= 32'd0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                min_size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_data_reg <= data_byte;
        end
        if (fire && rec_valid)
        begin
            out_rec_reg <= rec;
        end
    end

    assign out_valid           = out_valid_reg;
    assign stream_number       = out_rec_reg.stream;
    assign media_object_number = out_rec_reg.obj;
    assign payload_len         = out_rec_reg.size;
    assign last_of_packet      = out_rec_reg.last;
    assign size_underflow      = out_rec_reg.under;

endmodule

[rtl/core/asfdp_checker.sv]
// Port-level checks of the ASF data-packet header parser, bound to its top level.
// Depends on asf_data_packet_header_parser_top_macros.svh.
`include "asf_data_packet_header_parser_top_macros.svh"

module asfdp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] media_object_number,
    input logic [31:0] payload_len,
    input logic        last_of_packet,
    input logic        size_underflow
);

    `ASFDP_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(payload_len) && $stable(media_object_number))
    `ASFDP_ASSERT_NOW(a_stall_needs_backpressure, !out_valid, !in_stall)
    `ASFDP_ASSERT_NOW(a_underflow_clamped, out_valid && size_underflow,
        payload_len == 32'd0 && last_of_packet)
    `ASFDP_ASSERT_NOW(a_multi_len_narrow, out_valid && !last_of_packet,
        payload_len[31:16] == 16'h0 && !size_underflow)

endmodule

bind asf_data_packet_header_parser_top asfdp_checker u_asfdp_checker (.*);

[tb/sv/asfdp_payload_checker.sv]
// Checker for the ASF data-packet header parser: watches the byte, result and config channels.
// Predicts each payload record from the accepted bytes and compares it with the result transfer.
// Depends on asfdp_pkg for the parse phases and the payload record type.
module asfdp_payload_checker
    import asfdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [6:0]  stream_number,
    input  logic [31:0] media_object_number,
    input  logic [31:0] payload_len,
    input  logic        last_of_packet,
    input  logic        size_underflow,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output int          mismatches,
    output int          pending
);

    phase_t       cur_phase;
    logic [7:0]   len_flags;
    logic [7:0]   prop_bits;
    logic [31:0]  left;
    logic [31:0]  acc;
    logic [1:0]   acc_idx;
    logic [31:0]  pkt_size;
    logic [31:0]  pad_len;
    logic [31:0]  hdr_count;
    logic [6:0]   cur_stream;
    logic [31:0]  cur_object;
    logic [5:0]   pay_left;
    logic         multi_mode;
    logic [31:0]  min_size;
    payload_rec_t payload_q[$];
    payload_rec_t want;

    function automatic logic [31:0] code_bytes(input logic [1:0] code);
        return (code == 2'd3) ? 32'd4 : {30'd0, code};
    endfunction

    function automatic logic [31:0] field_len(input phase_t ph);
        case (ph)
            PH_PSIZE:  return code_bytes(len_flags[6:5]);
            PH_SEQ:    return code_bytes(len_flags[2:1]);
            PH_PAD:    return code_bytes(len_flags[4:3]);
            PH_TIME:   return 32'd6;
            PH_MOBJ:   return code_bytes(prop_bits[5:4]);
            PH_OFFSET: return code_bytes(prop_bits[3:2]);
            PH_REPLEN: return code_bytes(prop_bits[1:0]);
            PH_PLEN:   return 32'd2;
            PH_ECSKIP, PH_REPSKIP, PH_PAYSKIP, PH_PADSKIP: return left;
            default:   return 32'd1;
        endcase
    endfunction

    function automatic phase_t finish_field(input phase_t ph, input logic [31:0] v);
        logic [31:0]  total;
        logic [31:0]  body_size;
        logic         clamped;
        payload_rec_t rec;
        case (ph)
            PH_ECSKIP:  return PH_LENTYPE;
            PH_LENTYPE:
            begin
                len_flags = v[7:0];
                return PH_PROP;
            end
            PH_PROP:
            begin
                prop_bits = v[7:0];
                multi_mode = len_flags[0];
                return PH_PSIZE;
            end
            PH_PSIZE:
            begin
                pkt_size = v;
                return PH_SEQ;
            end
            PH_SEQ:     return PH_PAD;
            PH_PAD:
            begin
                pad_len = v;
                return PH_TIME;
            end
            PH_TIME:    return multi_mode ? PH_PFLAGS : PH_STREAM;
            PH_PFLAGS:
            begin
                pay_left = v[5:0];
                if (pay_left != 6'd0)
                    return PH_STREAM;
                left = pad_len;
                return PH_PADSKIP;
            end
            PH_STREAM:
            begin
                cur_stream = v[6:0];
                return PH_MOBJ;
            end
            PH_MOBJ:
            begin
                cur_object = v;
                return PH_OFFSET;
            end
            PH_OFFSET:  return PH_REPLEN;
            PH_REPLEN:
            begin
                left = v;
                return PH_REPSKIP;
            end
            PH_REPSKIP:
            begin
                if (multi_mode)
                    return PH_PLEN;
                total = (pkt_size < min_size) ? min_size : pkt_size;
                if (hdr_count > total || pad_len > total - hdr_count)
                begin
                    body_size = 32'd0;
                    clamped = 1'b1;
                end
                else
                begin
                    body_size = total - hdr_count - pad_len;
                    clamped = 1'b0;
                end
                rec.stream = cur_stream;
                rec.obj = cur_object;
                rec.size = body_size;
                rec.last = 1'b1;
                rec.under = clamped;
                payload_q.insert(payload_q.size(), rec);
                left = body_size;
                return PH_PAYSKIP;
            end
            PH_PLEN:
            begin
                rec.stream = cur_stream;
                rec.obj = cur_object;
                rec.size = {16'd0, v[15:0]};
                rec.last = (pay_left == 6'd1);
                rec.under = 1'b0;
                payload_q.insert(payload_q.size(), rec);
                pay_left = pay_left - 6'd1;
                left = {16'd0, v[15:0]};
                return PH_PAYSKIP;
            end
            PH_PAYSKIP:
            begin
                if (multi_mode && pay_left != 6'd0)
                    return PH_STREAM;
                left = pad_len;
                return PH_PADSKIP;
            end
            default:    return PH_FIRST;
        endcase
    endfunction

    // Resolve empty fields and skips until a phase that takes bytes.
    function automatic void advance_to(input phase_t start);
        phase_t p;
        p = start;
        while (field_len(p) == 32'd0)
            p = finish_field(p, 32'd0);
        cur_phase = p;
        left = field_len(p);
        acc = 32'd0;
        acc_idx = 2'd0;
    endfunction

    function automatic void take_byte(input logic [7:0] b);
        if (cur_phase == PH_FIRST)
        begin
            hdr_count = 32'd1;
            if (b[7])
            begin
                left = {28'd0, b[3:0]};
                advance_to(PH_ECSKIP);
            end
            else
            begin
                len_flags = b;
                advance_to(PH_PROP);
            end
        end
        else
        begin
            if (hdr_count != COUNT_MAX)
                hdr_count = hdr_count + 32'd1;
            case (cur_phase)
                PH_PSIZE, PH_PAD, PH_MOBJ, PH_REPLEN, PH_PLEN:
                begin
                    acc = acc | ({24'd0, b} << {acc_idx, 3'b000});
                    acc_idx = acc_idx + 2'd1;
                end
                PH_LENTYPE, PH_PROP, PH_PFLAGS, PH_STREAM:
                    acc = {24'd0, b};
                default: ;
            endcase
            left = left - 32'd1;
            if (left == 32'd0)
                advance_to(finish_field(cur_phase, acc));
        end
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_phase = PH_FIRST;
            len_flags = '0;
            prop_bits = '0;
            left = '0;
            acc = '0;
            acc_idx = '0;
            pkt_size = '0;
            pad_len = '0;
            hdr_count = '0;
            cur_stream = '0;
            cur_object = '0;
            pay_left = '0;
            multi_mode = 1'b0;
            min_size = '0;
            payload_q.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (payload_q.size() == 0)
                    note_mismatch($sformatf("result with none expected: stream %0h obj %0h size %0h",
                                            stream_number, media_object_number, payload_len));
                else
                begin
                    want = payload_q.pop_front();
                    if (stream_number !== want.stream)
                        note_mismatch($sformatf("stream_number %0h, want %0h",
                                                stream_number, want.stream));
                    if (media_object_number !== want.obj)
                        note_mismatch($sformatf("media_object_number %0h, want %0h",
                                                media_object_number, want.obj));
                    if (payload_len !== want.size)
                        note_mismatch($sformatf("payload_len %0h, want %0h",
                                                payload_len, want.size));
                    if (last_of_packet !== want.last)
                        note_mismatch($sformatf("last_of_packet %0b, want %0b",
                                                last_of_packet, want.last));
                    if (size_underflow !== want.under)
                        note_mismatch($sformatf("size_underflow %0b, want %0b",
                                                size_underflow, want.under));
                end
            end
            if (cfg_valid && cfg_ready)
                min_size = cfg_data;
            if (in_valid && !in_stall)
                take_byte(data_byte);
            pending = payload_q.size();
        end
    end

endmodule

[tb/sv/testbench.sv]
// Top of the ASF data-packet header parser testbench: clock, reset, byte stream and config writes.
// Builds randomized packets, drives them with random idling and reads the verdict from
// asfdp_payload_checker; depends on asf_data_packet_header_parser_top.
module testbench;

    localparam logic [7:0] OPENING [19] = '{
        8'h80, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
        8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hC0
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [6:0]  stream_number;
    logic [31:0] media_object_number;
    logic [31:0] payload_len;
    logic        last_of_packet;
    logic        size_underflow;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = 32'd0;

    int          mismatches;
    int          pending;
    logic [7:0]  stream_q[$];
    int unsigned phase_bytes = 0;
    logic [31:0] min_now = 32'd0;
    bit          idling = 1'b1;
    bit          hold_go = 1'b0;
    bit          long_hold = 1'b0;
    int          send_gap = 0;
    int          recv_gap = 0;

    asf_data_packet_header_parser_top dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .data_byte           (data_byte),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .stream_number       (stream_number),
        .media_object_number (media_object_number),
        .payload_len         (payload_len),
        .last_of_packet      (last_of_packet),
        .size_underflow      (size_underflow),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_data            (cfg_data)
    );

    asfdp_payload_checker payload_check (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .data_byte           (data_byte),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .stream_number       (stream_number),
        .media_object_number (media_object_number),
        .payload_len         (payload_len),
        .last_of_packet      (last_of_packet),
        .size_underflow      (size_underflow),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_data            (cfg_data),
        .mismatches          (mismatches),
        .pending             (pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("FAILED: results differ");
        $finish;
    end

    // Hold the byte until its transfer; advance to the next queued byte or idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_byte <= 8'd0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                void'(stream_q.pop_front());
            if (in_valid && in_stall)
                ;
            else if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (stream_q.size() == 0)
                in_valid <= 1'b0;
            else if (idling && $urandom_range(0, 15) == 0)
            begin
                send_gap = $urandom_range(0, 12);
                in_valid <= 1'b0;
            end
            else
            begin
                in_valid <= 1'b1;
                data_byte <= stream_q[0];
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap = 0;
        end
        else if (long_hold)
            out_stall <= 1'b1;
        else if (recv_gap > 0)
        begin
            recv_gap--;
            out_stall <= 1'b1;
        end
        else if (idling && $urandom_range(0, 11) == 0)
        begin
            recv_gap = $urandom_range(0, 12);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Hold off the result side long enough to back up the byte input.
    initial
    begin
        wait (hold_go);
        @(negedge clk);
        long_hold = 1'b1;
        repeat (300) @(negedge clk);
        long_hold = 1'b0;
    end

    function automatic int unsigned field_bytes(input logic [1:0] code);
        return (code == 2'd3) ? 4 : int'(code);
    endfunction

    task automatic push_le(input logic [31:0] v, input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
        begin
            stream_q.insert(stream_q.size(), v[8*i +: 8]);
            phase_bytes++;
        end
    endtask

    task automatic push_noise(input int unsigned n);
        repeat (n)
        begin
            stream_q.insert(stream_q.size(), 8'($urandom));
            phase_bytes++;
        end
    endtask

    // kind: 0 either mode, 1 multi-payload, 2 single payload
    task automatic queue_packet(input int kind);
        logic [7:0]  ltf;
        logic [7:0]  pf;
        logic [7:0]  lead;
        logic [31:0] psz;
        logic [31:0] padv;
        logic [31:0] total;
        logic [31:0] body;
        int unsigned lp, ls, lpd, lm, lo, lr;
        int unsigned n_ec, hdr, npay, rep, plen;
        bit          ec;
        ec = ($urandom_range(0, 3) == 0);
        ltf = 8'($urandom);
        pf = 8'($urandom);
        if (kind == 1)
            ltf[0] = 1'b1;
        if (kind == 2)
            ltf[0] = 1'b0;
        if (!ec)
            ltf[7] = 1'b0;
        lp = field_bytes(ltf[6:5]);
        ls = field_bytes(ltf[2:1]);
        lpd = field_bytes(ltf[4:3]);
        lm = field_bytes(pf[5:4]);
        lo = field_bytes(pf[3:2]);
        lr = field_bytes(pf[1:0]);
        n_ec = ec ? $urandom_range(0, 15) : 0;
        padv = (lpd == 0 || $urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 12));
        rep = (lr == 0) ? 0 : $urandom_range(0, 6);
        hdr = 3 + (ec ? n_ec + 1 : 0) + 6 + lp + ls + lpd + lm + lo + lr + rep;
        if (ltf[0])
            psz = $urandom;
        else if ($urandom_range(0, 7) == 0)
            psz = $urandom_range(0, hdr + padv);
        else
            psz = hdr + padv + $urandom_range(0, 24);
        case (lp)
            0: psz = 32'd0;
            1: psz[31:8] = '0;
            2: psz[31:16] = '0;
            default: ;
        endcase
        if (ec)
        begin
            lead = 8'($urandom);
            lead[7] = 1'b1;
            lead[3:0] = n_ec[3:0];
            push_le(lead, 1);
            push_noise(n_ec);
        end
        push_le(ltf, 1);
        push_le(pf, 1);
        push_le(psz, lp);
        push_noise(ls);
        push_le(padv, lpd);
        push_noise(6);
        if (ltf[0])
        begin
            case ($urandom_range(0, 29))
                0: npay = 0;
                1: npay = 63;
                default: npay = $urandom_range(1, 4);
            endcase
            lead = 8'($urandom);
            lead[5:0] = npay[5:0];
            push_le(lead, 1);
            repeat (npay)
            begin
                rep = (lr == 0 || npay > 4) ? 0 : $urandom_range(0, 6);
                if (npay > 4)
                    plen = $urandom_range(0, 2);
                else if ($urandom_range(0, 9) == 0)
                    plen = $urandom_range(0, 300);
                else
                    plen = $urandom_range(0, 8);
                push_noise(1 + lm + lo);
                push_le(rep, lr);
                push_noise(rep);
                push_le(plen, 2);
                push_noise(plen);
            end
            push_noise(padv);
        end
        else
        begin
            push_noise(1 + lm + lo);
            push_le(rep, lr);
            push_noise(rep);
            total = (psz < min_now) ? min_now : psz;
            body = (hdr > total || padv > total - hdr) ? 32'd0 : total - hdr - padv;
            // leave the packet open when the size bound makes the payload huge
            if (body < 32'd100000)
            begin
                push_noise(body);
                push_noise(padv);
            end
        end
    endtask

    task automatic wait_idle();
        int unsigned spin;
        spin = 0;
        while (stream_q.size() != 0)
            @(negedge clk);
        while (pending != 0 && spin < 20000)
        begin
            @(negedge clk);
            spin++;
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic write_min(input logic [31:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        min_now = v;
    endtask

    initial
    begin
        int          p;
        logic [31:0] v;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        foreach (OPENING[i])
            push_le(OPENING[i], 1);
        wait_idle();
        for (p = 0; p < 4; p++)
        begin
            case (p)
                0: v = 32'd0;
                1: v = $urandom_range(1, 60);
                2: v = $urandom_range(100, 220);
                default: v = $urandom_range(30, 90);
            endcase
            write_min(v);
            phase_bytes = 0;
            while (phase_bytes < 350)
                queue_packet(0);
            if (p == 2)
                hold_go = 1'b1;
            wait_idle();
        end
        idling = 1'b0;
        write_min(32'hFFFF_FFFF);
        repeat (3) queue_packet(1);
        queue_packet(2);
        wait_idle();
        if (mismatches == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
